// ===== rtl/yzd_pkg.sv =====
// ---------------------------------------------------------------------------
// yzd_pkg
// Shared widths, constants and types of the Yaz0 stream decoder.
// ---------------------------------------------------------------------------
package yzd_pkg;

   localparam int WINDOW_DEPTH     = 4096;
   localparam int HIST_ADDR_W      = $clog2(WINDOW_DEPTH);
   localparam int BYTES_PER_RESULT = 8;
   localparam int LANE_W           = $clog2(BYTES_PER_RESULT);
   localparam int COUNT_W          = 4;
   localparam int PACK_W           = 8 * BYTES_PER_RESULT;
   localparam int SIZE_W           = 27;
   localparam int LEN_W            = 9;
   localparam int HEADER_W         = 5;
   localparam int HEADER_BYTES_DEF = 16;

   localparam logic [LEN_W-1:0] SHORT_LEN_BIAS = 9'd2;
   localparam logic [LEN_W-1:0] LONG_LEN_BIAS  = 9'h12;

   // Parse phase codes
   localparam logic [1:0] PH_CODE   = 2'd0;
   localparam logic [1:0] PH_TOKEN2 = 2'd1;
   localparam logic [1:0] PH_EXTRA  = 2'd2;

   // One byte handed to the packer
   typedef struct packed {
      logic put;    // byte is valid this cycle
      logic flush;  // close the word with this byte
      logic last;   // last result of the current transaction
      logic done;   // output size reached after this byte
   } yzd_put_type;

endpackage

// ===== rtl/yaz0_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// yaz0_stream_decoder
// Yaz0 decompressor: one compressed byte per transaction, packed output words.
// ---------------------------------------------------------------------------
// Header, group code and partial token bytes pass through S_DECODE, a
// literal through S_DECODE and S_LIT, a copy of L bytes through S_DECODE
// then S_READ and S_COPY per byte; S_LIT and S_COPY wait while the result
// side stalls. A read then a write of the window per byte sets the copy rate.
// One transaction is in work at a time; req_tready is low meanwhile.
// Reset (synchronous, active high) clears the parse state and out_size; the
// history window is not cleared, as references before the stream read zero.
module yaz0_stream_decoder
   import yzd_pkg::*;
#(
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   // compressed input
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,  // [7:0] in_byte
   input  logic              req_tuser,  // new_stream
   // decoded output
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,  // [63:0] out_data, [67:64] out_count
   output logic              rsp_tlast,  // run_last
   output logic              rsp_tuser,  // stream_done
   // out_size register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_LIT,
      S_READ,
      S_COPY
   } state_type;

   state_type               state_ff, state_in;
   logic [7:0]              byte_ff, byte_in;
   logic [SIZE_W-1:0]       out_size_ff, out_size_in;
   logic [HIST_ADDR_W-1:0]  wp_ff, wp_in;
   logic [SIZE_W-1:0]       prod_ff, prod_in;
   logic [HEADER_W-1:0]     header_ff, header_in;
   logic [7:0]              group_ff, group_in;
   logic [3:0]              bits_ff, bits_in;
   logic [1:0]              phase_ff, phase_in;
   logic [7:0]              token_ff, token_in;
   logic [HIST_ADDR_W-1:0]  dist_ff, dist_in;
   logic                    finished_ff, finished_in;
   logic [LEN_W-1:0]        len_ff, len_in;

   yzd_put_type             put;
   logic [7:0]              put_byte;
   logic                    out_free;
   logic [LANE_W-1:0]       pack_count;
   logic [SIZE_W-1:0]       prod_next;
   logic                    size_hit;
   logic                    src_ok;
   logic                    rd_en;
   logic [HIST_ADDR_W-1:0]  rd_addr;
   logic [7:0]              rd_data;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);

   // count after the byte being put, and whether it reaches the size
   assign prod_next = prod_ff + 1'b1;
   assign size_hit  = (prod_next >= out_size_ff);
   // source position before stream start reads zero
   assign src_ok    = (prod_ff >= (SIZE_W'(dist_ff) + 1'b1));
   assign rd_addr   = wp_ff - dist_ff - 1'b1;
   assign rd_en     = (state_ff == S_READ);

   always_comb begin
      put      = '0;
      put_byte = byte_ff;
      if (state_ff == S_LIT) begin
         put.put  = out_free;
         put.last = 1'b1;
      end else if (state_ff == S_COPY) begin
         put.put  = out_free;
         put_byte = src_ok ? rd_data : 8'h00;
         put.last = (len_ff == LEN_W'(1)) || size_hit;
      end
      put.done  = size_hit;
      put.flush = put.last || size_hit || (pack_count == LANE_W'(BYTES_PER_RESULT - 1));
   end

   always_comb begin
      state_in    = state_ff;
      byte_in     = byte_ff;
      out_size_in = out_size_ff;
      wp_in       = wp_ff;
      prod_in     = prod_ff;
      header_in   = header_ff;
      group_in    = group_ff;
      bits_in     = bits_ff;
      phase_in    = phase_ff;
      token_in    = token_ff;
      dist_in     = dist_ff;
      finished_in = finished_ff;
      len_in      = len_ff;

      if (csr_valid) begin
         out_size_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               byte_in  = req_tdata;
               state_in = S_DECODE;
               // restart the parse on the first byte of a new stream
               if (req_tuser) begin
                  wp_in       = '0;
                  prod_in     = '0;
                  header_in   = HEADER_W'(HEADER_BYTES);
                  group_in    = '0;
                  bits_in     = '0;
                  phase_in    = PH_CODE;
                  token_in    = '0;
                  dist_in     = '0;
                  finished_in = 1'b0;
               end
            end
         end

         S_DECODE: begin
            state_in = S_IDLE;
            if (finished_ff || (prod_ff >= out_size_ff)) begin
               // size reached: drop everything until the next stream
               finished_in = 1'b1;
            end else if (header_ff != '0) begin
               header_in = header_ff - 1'b1;
            end else if (phase_ff == PH_TOKEN2) begin
               dist_in = {token_ff[3:0], byte_ff};
               if (token_ff[7:4] == 4'd0) begin
                  phase_in = PH_EXTRA;
               end else begin
                  len_in   = LEN_W'(token_ff[7:4]) + SHORT_LEN_BIAS;
                  state_in = S_READ;
               end
            end else if (phase_ff == PH_EXTRA) begin
               len_in   = LEN_W'(byte_ff) + LONG_LEN_BIAS;
               state_in = S_READ;
            end else begin
               // unused phase falls back to the code phase
               phase_in = PH_CODE;
               if (bits_ff == 4'd0) begin
                  group_in = byte_ff;
                  bits_in  = 4'd8;
               end else if (group_ff[7]) begin
                  state_in = S_LIT;
               end else begin
                  token_in = byte_ff;
                  phase_in = PH_TOKEN2;
               end
            end
         end

         S_LIT: begin
            if (put.put) begin
               wp_in       = wp_ff + 1'b1;
               prod_in     = prod_next;
               finished_in = size_hit;
               group_in    = {group_ff[6:0], 1'b0};
               bits_in     = bits_ff - 1'b1;
               state_in    = S_IDLE;
            end
         end

         S_READ: begin
            state_in = S_COPY;
         end

         S_COPY: begin
            if (put.put) begin
               wp_in   = wp_ff + 1'b1;
               prod_in = prod_next;
               len_in  = len_ff - 1'b1;
               if (put.last) begin
                  finished_in = size_hit;
                  group_in    = {group_ff[6:0], 1'b0};
                  bits_in     = (bits_ff != 4'd0) ? bits_ff - 1'b1 : bits_ff;
                  phase_in    = PH_CODE;
                  state_in    = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         out_size_ff <= '0;
         wp_ff       <= '0;
         prod_ff     <= '0;
         header_ff   <= HEADER_W'(HEADER_BYTES);
         group_ff    <= '0;
         bits_ff     <= '0;
         phase_ff    <= PH_CODE;
         token_ff    <= '0;
         dist_ff     <= '0;
         finished_ff <= 1'b0;
         len_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         out_size_ff <= out_size_in;
         wp_ff       <= wp_in;
         prod_ff     <= prod_in;
         header_ff   <= header_in;
         group_ff    <= group_in;
         bits_ff     <= bits_in;
         phase_ff    <= phase_in;
         token_ff    <= token_in;
         dist_ff     <= dist_in;
         finished_ff <= finished_in;
         len_ff      <= len_in;
      end
   end

   // payload hold register, no reset
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   yzd_history u_history (
      .clock   (clock),
      .wr_en   (put.put),
      .wr_addr (wp_ff),
      .wr_data (put_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   yzd_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .put        (put),
      .put_byte   (put_byte),
      .out_free   (out_free),
      .pack_count (pack_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // no half-filled word may be left behind when a transaction ends
   a_idle_pack_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (pack_count == '0))
      else $error("partial word left in packer while idle");

   // nothing is produced once the size has been reached
   a_finished_quiet: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !put.put)
      else $error("byte produced after stream finished");

   // a full word must close
   a_full_flush: assert property (@(posedge clock) disable iff (reset)
      (put.put && (pack_count == LANE_W'(BYTES_PER_RESULT - 1))) |-> put.flush)
      else $error("packer overflow");

   // copy never runs with an exhausted length
   a_copy_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY || state_ff == S_READ) |-> (len_ff != '0))
      else $error("copy with zero remaining length");

endmodule

// ===== rtl/yzd_history.sv =====
// ---------------------------------------------------------------------------
// yzd_history
// History window: single write port, single registered read port.
// ---------------------------------------------------------------------------
module yzd_history
   import yzd_pkg::*;
(
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [HIST_ADDR_W-1:0] wr_addr,
   input  logic [7:0]             wr_data,
   input  logic                   rd_en,
   input  logic [HIST_ADDR_W-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [WINDOW_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/yzd_packer.sv =====
// ---------------------------------------------------------------------------
// yzd_packer
// Gathers decoded bytes into 64-bit words and holds the result register.
// ---------------------------------------------------------------------------
module yzd_packer
   import yzd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  yzd_put_type       put,
   input  logic [7:0]        put_byte,
   output logic              out_free,
   output logic [LANE_W-1:0] pack_count,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,  // [63:0] out_data, [67:64] out_count, rest zero
   output logic              rsp_tlast,  // run_last
   output logic              rsp_tuser   // stream_done
);

   logic [PACK_W-1:0]  acc_ff, acc_in, merged;
   logic [LANE_W-1:0]  n_ff, n_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PACK_W-1:0]  rsp_data_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_last_ff, rsp_done_ff;
   logic               load;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load     = put.put && put.flush;

   always_comb begin
      merged = acc_ff;
      for (int i = 0; i < BYTES_PER_RESULT; i++) begin
         if (n_ff == LANE_W'(i)) begin
            merged[8*i +: 8] = put_byte;
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      n_in   = n_ff;
      if (put.put) begin
         if (put.flush) begin
            acc_in = '0;
            n_in   = '0;
         end else begin
            acc_in = merged;
            n_in   = n_ff + 1'b1;
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff  <= merged;
         rsp_count_ff <= COUNT_W'(n_ff) + 1'b1;
         rsp_last_ff  <= put.last;
         rsp_done_ff  <= put.done;
      end
   end

   assign pack_count = n_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_count_ff, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

endmodule
